### rtl/kcq_pkg.sv
// Package for the k-means colour quantizer: shared constants, chain and
// control structs, and the sequencer state type. No dependencies.
`default_nettype none
package kcq_pkg;
  localparam int MAX_POINTS_DEF    = 4096;
  localparam int MAX_CENTROIDS_DEF = 16;
  localparam int MAX_ROUNDS_DEF    = 64;

  localparam int IDX_W  = 6;   // holds any centroid index up to 63
  localparam int K_W    = 7;   // holds k up to 64
  localparam int DIST_W = 10;  // squared distance, at most 900
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic              valid;
    logic [15:0]       colour;
    logic [DIST_W-1:0] sqd;
    logic [IDX_W-1:0]  idx;
  } chain_t;

  typedef struct packed {
    logic             clr_acc;
    logic             div_en;
    logic [1:0]       div_bit;
    logic             commit;
    logic             clr_all;
    logic             seed_we;
    logic [IDX_W-1:0] seed_idx;
    logic [15:0]      seed_data;
    logic [K_W-1:0]   k;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STREAM,
    ST_DRAIN,
    ST_DIV,
    ST_COMMIT,
    ST_CHECK,
    ST_EMIT
  } state_t;

  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_SEED   = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;
endpackage
`default_nettype wire

### rtl/kcq_if.sv
// Valid/ready channel interfaces for the quantizer's input and result sides.
// No dependencies.
`default_nettype none
interface kcq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] colour;
  modport source (output valid, output opcode, output colour, input ready);
  modport sink   (input valid, input opcode, input colour, output ready);
endinterface

interface kcq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] centroid_colour;
  logic [3:0]  centroid_index;
  logic        last;
  logic        converged;
  logic        overflow;
  logic [6:0]  rounds_used;
  modport source (output valid, output centroid_colour, output centroid_index,
                  output last, output converged, output overflow,
                  output rounds_used, input ready);
  modport sink   (input valid, input centroid_colour, input centroid_index,
                  input last, input converged, input overflow,
                  input rounds_used, output ready);
endinterface
`default_nettype wire

### rtl/kmeans_colour_quantizer.sv
// K-means colour quantizer top level: point memory, round sequencer and the
// row of centroid cells. Depends on kcq_pkg, kcq_if and kcq_cell.
//
//   channel   dir  payload                                         handshake
//   in_ch     in   opcode, colour                                  valid/ready
//   out_ch    out  centroid_colour, centroid_index, last,
//                  converged, overflow, rounds_used                valid/ready
//   cfg_*     in   centroid_count                                  write enable
//
// Point and seed loads are accepted while idle. Each round of a run streams
// the P points from the single read port of the point memory through the
// cell row, drains the row, then runs four divider steps, commit and check;
// the k palette entries are then emitted. Reset is synchronous, active low.
// The input is held off while a run is in progress; a stalled result holds
// the emit sequence.
`default_nettype none
module kmeans_colour_quantizer
  import kcq_pkg::*;
#(
  parameter int MAX_POINTS    = MAX_POINTS_DEF,
  parameter int MAX_CENTROIDS = MAX_CENTROIDS_DEF,
  parameter int MAX_ROUNDS    = MAX_ROUNDS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  kcq_in_if.sink          in_ch,
  kcq_out_if.source       out_ch,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data
);
  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PW    = $clog2(MAX_POINTS + 1);
  localparam int SW    = PW + 4;
  localparam int CW    = $clog2(MAX_CENTROIDS + 1);
  localparam int EW    = $clog2(MAX_CENTROIDS);
  localparam int RW    = $clog2(MAX_ROUNDS + 1);
  localparam int DW    = $clog2(MAX_CENTROIDS + 3);
  localparam int DRAIN = MAX_CENTROIDS + 2;

  logic [15:0]   mem [MAX_POINTS];
  logic [15:0]   rd_data_r;
  logic          rd_valid_r;

  state_t        state_r, state_nxt;
  logic [4:0]    kcfg_r;
  logic [PW-1:0] point_total_r;
  logic [CW-1:0] seed_total_r;
  logic          dropped_r;
  logic [PW-1:0] addr_r;
  logic [DW-1:0] drain_r;
  logic [1:0]    bit_r;
  logic [RW-1:0] rounds_r;
  logic          conv_r;
  logic [EW-1:0] emit_r;

  logic [CW-1:0] k_eff;
  logic          in_fire, issue, emit_load, emit_last, any_changed;
  cell_ctl_t     ctl;
  chain_t        chain [MAX_CENTROIDS+1];
  logic [15:0]   cent [MAX_CENTROIDS];
  logic [MAX_CENTROIDS-1:0] changed;

  logic          out_valid_r;
  logic [15:0]   out_colour_r;
  logic [3:0]    out_index_r;
  logic          out_last_r, out_conv_r, out_ovf_r;
  logic [6:0]    out_rounds_r;

  always_comb begin
    if (kcfg_r == 5'd0) begin
      k_eff = CW'(1);
    end else if (32'(kcfg_r) > MAX_CENTROIDS) begin
      k_eff = CW'(MAX_CENTROIDS);
    end else begin
      k_eff = CW'(kcfg_r);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign issue       = (state_r == ST_STREAM);
  assign emit_load   = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign emit_last   = (CW'(emit_r) + CW'(1) == k_eff);
  assign any_changed = |changed;

  always_ff @(posedge clk) begin
    if (in_fire && (in_ch.opcode == OP_POINT) && (32'(point_total_r) < MAX_POINTS)) begin
      mem[point_total_r[AW-1:0]] <= in_ch.colour;
    end
    rd_data_r <= mem[addr_r[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.opcode == OP_RUN)) begin
          state_nxt = (PW'(k_eff) < point_total_r) ? ST_STREAM : ST_EMIT;
        end
      end
      ST_STREAM: begin
        if (addr_r + PW'(1) == point_total_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_r == DW'(DRAIN)) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (bit_r == 2'd0) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!any_changed || (rounds_r == RW'(MAX_ROUNDS))) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_STREAM;
        end
      end
      ST_EMIT: begin
        if (emit_load && emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.k         = K_W'(k_eff);
    ctl.div_bit   = bit_r;
    ctl.clr_acc   = (state_r == ST_IDLE) || (state_r == ST_COMMIT);
    ctl.div_en    = (state_r == ST_DIV);
    ctl.commit    = (state_r == ST_COMMIT);
    ctl.clr_all   = emit_load && emit_last;
    ctl.seed_we   = in_fire && (in_ch.opcode == OP_SEED) &&
                    (32'(seed_total_r) < MAX_CENTROIDS);
    ctl.seed_idx  = IDX_W'(seed_total_r);
    ctl.seed_data = in_ch.colour;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      kcfg_r        <= 5'd16;
      point_total_r <= '0;
      seed_total_r  <= '0;
      dropped_r     <= 1'b0;
      addr_r        <= '0;
      drain_r       <= '0;
      bit_r         <= 2'd3;
      rounds_r      <= '0;
      conv_r        <= 1'b1;
      emit_r        <= '0;
      rd_valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= issue;
      if (cfg_wr_en) kcfg_r <= cfg_wr_data;
      if (in_fire && (in_ch.opcode == OP_POINT)) begin
        if (32'(point_total_r) < MAX_POINTS) point_total_r <= point_total_r + PW'(1);
        else dropped_r <= 1'b1;
      end
      if (in_fire && (in_ch.opcode == OP_SEED)) begin
        if (32'(seed_total_r) < MAX_CENTROIDS) seed_total_r <= seed_total_r + CW'(1);
        else dropped_r <= 1'b1;
      end
      if (in_fire && (in_ch.opcode == OP_RUN)) begin
        rounds_r <= '0;
        conv_r   <= 1'b1;
        emit_r   <= '0;
      end
      if (issue) addr_r <= addr_r + PW'(1);
      else if (state_r == ST_CHECK) addr_r <= '0;
      if (state_r == ST_DRAIN) drain_r <= drain_r + DW'(1);
      else drain_r <= '0;
      if (state_r == ST_DIV) bit_r <= bit_r - 2'd1;
      else bit_r <= 2'd3;
      if (state_r == ST_COMMIT) rounds_r <= rounds_r + RW'(1);
      if (state_r == ST_CHECK) conv_r <= !any_changed;
      if (emit_load) emit_r <= emit_r + EW'(1);
      if (ctl.clr_all) begin
        point_total_r <= '0;
        seed_total_r  <= '0;
        dropped_r     <= 1'b0;
        addr_r        <= '0;
      end
    end
  end

  assign chain[0] = '{valid: rd_valid_r, colour: rd_data_r, sqd: DIST_MAX, idx: '0};

  for (genvar g = 0; g < MAX_CENTROIDS; g++) begin : g_cell
    kcq_cell #(
      .IDX   (g),
      .CNT_W (PW),
      .SUM_W (SW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1]),
      .acc_i      (chain[MAX_CENTROIDS]),
      .ctl_i      (ctl),
      .centroid_o (cent[g]),
      .changed_o  (changed[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit_load) begin
      out_colour_r <= cent[emit_r];
      out_index_r  <= 4'(emit_r);
      out_last_r   <= emit_last;
      out_conv_r   <= conv_r;
      out_ovf_r    <= dropped_r;
      out_rounds_r <= 7'(rounds_r);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.centroid_colour = out_colour_r;
  assign out_ch.centroid_index  = out_index_r;
  assign out_ch.last            = out_last_r;
  assign out_ch.converged       = out_conv_r;
  assign out_ch.overflow        = out_ovf_r;
  assign out_ch.rounds_used     = out_rounds_r;
endmodule
`default_nettype wire

### rtl/kcq_cell.sv
// One centroid cell: distance compare stage, cluster accumulators and a
// radix-2 divider for the mean. Depends on kcq_pkg.
`default_nettype none
module kcq_cell
  import kcq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 13,
  parameter int SUM_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire chain_t           chain_i,
  output chain_t                chain_o,
  input  wire chain_t           acc_i,
  input  wire cell_ctl_t        ctl_i,
  output logic [15:0]           centroid_o,
  output logic                  changed_o
);
  chain_t             chain_r, chain_nxt;
  logic [15:0]        cent_r;
  logic               changed_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_r [4];
  logic [SUM_W-1:0]   sum_nxt [4];
  logic [15:0]        quo_r, quo_nxt;
  logic               active;
  logic               hit;
  logic [DIST_W-1:0]  cand_sqd;
  logic [SUM_W-1:0]   shifted;
  logic [15:0]        new_cent;

  assign active = K_W'(IDX) < ctl_i.k;
  assign hit    = acc_i.valid && (acc_i.idx == IDX_W'(IDX));

  always_comb begin
    logic [3:0] a, b, d;
    cand_sqd = '0;
    for (int l = 0; l < 4; l++) begin
      a = chain_i.colour[4*l +: 4];
      b = cent_r[4*l +: 4];
      d = (a > b) ? (a - b) : (b - a);
      cand_sqd = cand_sqd + DIST_W'(d) * DIST_W'(d);
    end
  end

  always_comb begin
    chain_nxt = chain_i;
    if (chain_i.valid && active && (cand_sqd < chain_i.sqd)) begin
      chain_nxt.sqd = cand_sqd;
      chain_nxt.idx = IDX_W'(IDX);
    end
  end

  assign shifted = SUM_W'(cnt_r) << ctl_i.div_bit;

  always_comb begin
    quo_nxt = quo_r;
    for (int l = 0; l < 4; l++) begin
      sum_nxt[l] = sum_r[l];
      if (sum_r[l] >= shifted) begin
        sum_nxt[l] = sum_r[l] - shifted;
        quo_nxt[{2'(l), ctl_i.div_bit}] = 1'b1;
      end
    end
  end

  assign new_cent = (cnt_r == '0) ? 16'h0000 : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r.valid <= 1'b0;
    end else begin
      chain_r.valid <= chain_nxt.valid;
    end
    chain_r.colour <= chain_nxt.colour;
    chain_r.sqd    <= chain_nxt.sqd;
    chain_r.idx    <= chain_nxt.idx;
  end

  always_ff @(posedge clk) begin
    if (ctl_i.clr_acc) begin
      cnt_r <= '0;
      quo_r <= '0;
      for (int l = 0; l < 4; l++) sum_r[l] <= '0;
    end else if (hit) begin
      cnt_r <= cnt_r + CNT_W'(1);
      for (int l = 0; l < 4; l++) sum_r[l] <= sum_r[l] + SUM_W'(acc_i.colour[4*l +: 4]);
    end else if (ctl_i.div_en) begin
      quo_r <= quo_nxt;
      for (int l = 0; l < 4; l++) sum_r[l] <= sum_nxt[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cent_r    <= '0;
      changed_r <= 1'b0;
    end else if (ctl_i.clr_all) begin
      cent_r    <= '0;
      changed_r <= 1'b0;
    end else if (ctl_i.seed_we && (ctl_i.seed_idx == IDX_W'(IDX))) begin
      cent_r <= ctl_i.seed_data;
    end else if (ctl_i.commit) begin
      if (active) begin
        changed_r <= (new_cent != cent_r);
        cent_r    <= new_cent;
      end else begin
        changed_r <= 1'b0;
      end
    end
  end

  assign chain_o    = chain_r;
  assign centroid_o = cent_r;
  assign changed_o  = changed_r;
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for kmeans_colour_quantizer: loads points and seeds,
// runs clustering jobs and checks every palette entry against a local predictor.
// Depends on kcq_pkg, kcq_if and the RTL of the block.
`timescale 1ns / 100ps
module tb_top;
  import kcq_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [15:0] colour;
    logic [3:0]  idx;
    logic        last;
    logic        conv;
    logic        ovf;
    logic [6:0]  rounds;
  } palette_entry_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;

  kcq_in_if  in_if ();
  kcq_out_if out_if ();

  kmeans_colour_quantizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if.sink),
    .out_ch     (out_if.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [15:0]    point_q[$];
  logic [15:0]    seed_mem[MAX_CENTROIDS_DEF];
  int             seed_cnt;
  bit             dropped;
  logic [4:0]     k_reg;
  palette_entry_t palette_q[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_len;
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  mismatches = 0;
  longint cycles = 0;

  function automatic int colour_dist(logic [15:0] a, logic [15:0] b);
    int acc;
    int d;
    acc = 0;
    for (int lane = 0; lane < 4; lane++) begin
      d = int'(a[lane*4 +: 4]) - int'(b[lane*4 +: 4]);
      acc += d * d;
    end
    return acc;
  endfunction

  task automatic cluster_and_predict();
    int             k;
    int             rounds;
    bit             conv;
    bit             same;
    int             members[MAX_CENTROIDS_DEF];
    int             sums[MAX_CENTROIDS_DEF][4];
    int             best;
    int             best_d;
    int             d;
    logic [15:0]    nc;
    palette_entry_t e;
    k = k_reg;
    if (k == 0) k = 1;
    if (k > MAX_CENTROIDS_DEF) k = MAX_CENTROIDS_DEF;
    rounds = 0;
    conv = 1'b1;
    if (k < point_q.size()) begin
      conv = 1'b0;
      while (rounds < MAX_ROUNDS_DEF && !conv) begin
        rounds++;
        for (int i = 0; i < MAX_CENTROIDS_DEF; i++) begin
          members[i] = 0;
          for (int l = 0; l < 4; l++) sums[i][l] = 0;
        end
        foreach (point_q[p]) begin
          best = 0;
          best_d = colour_dist(point_q[p], seed_mem[0]);
          for (int i = 1; i < k; i++) begin
            d = colour_dist(point_q[p], seed_mem[i]);
            if (d < best_d) begin
              best_d = d;
              best = i;
            end
          end
          members[best]++;
          for (int l = 0; l < 4; l++) sums[best][l] += point_q[p][l*4 +: 4];
        end
        same = 1'b1;
        for (int i = 0; i < k; i++) begin
          nc = '0;
          if (members[i] != 0)
            for (int l = 0; l < 4; l++) nc[l*4 +: 4] = 4'(sums[i][l] / members[i]);
          if (nc != seed_mem[i]) same = 1'b0;
          seed_mem[i] = nc;
        end
        conv = same;
      end
    end
    for (int i = 0; i < k; i++) begin
      e.colour = seed_mem[i];
      e.idx    = 4'(i);
      e.last   = (i == k - 1);
      e.conv   = conv;
      e.ovf    = dropped;
      e.rounds = 7'(rounds);
      palette_q.push_back(e);
    end
    point_q.delete();
    seed_cnt = 0;
    foreach (seed_mem[i]) seed_mem[i] = '0;
    dropped = 1'b0;
  endtask

  task automatic send_item(logic [1:0] op, logic [15:0] colour);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.colour <= colour;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    case (op)
      OP_POINT: begin
        if (point_q.size() < MAX_POINTS_DEF) point_q.push_back(colour);
        else dropped = 1'b1;
      end
      OP_SEED: begin
        if (seed_cnt < MAX_CENTROIDS_DEF) seed_mem[seed_cnt++] = colour;
        else dropped = 1'b1;
      end
      OP_RUN: cluster_and_predict();
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (palette_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_k(logic [4:0] k);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    k_reg = k;
  endtask

  // one job: distinct seeds, random points with occasional unused opcodes, then run
  task automatic random_job(int n_points, int n_seeds);
    logic [15:0] used[$];
    logic [15:0] c;
    for (int s = 0; s < n_seeds; s++) begin
      do c = 16'($urandom); while (c inside {used});
      used.push_back(c);
      send_item(OP_SEED, c);
    end
    for (int p = 0; p < n_points; p++) begin
      if ($urandom_range(9) == 0) send_item(OP_UNUSED, 16'($urandom));
      send_item(OP_POINT, $urandom_range(3) == 0 ? 16'($urandom) :
                          16'($urandom) & 16'h3333);
    end
    send_item(OP_RUN, 16'($urandom));
  endtask

  task automatic test_default_k();
    random_job(20, 16);
    random_job(5, 3);
  endtask

  task automatic test_k_extremes();
    write_k(5'd0);
    send_item(OP_SEED, 16'hFFFF);
    send_item(OP_POINT, 16'h0000);
    send_item(OP_POINT, 16'hFFFF);
    send_item(OP_RUN, 16'h0000);
    write_k(5'd31);
    random_job(18, 16);
    write_k(5'd17);
    random_job(3, 2);
    write_k(5'd4);
    send_item(OP_SEED, 16'h1234);
    send_item(OP_SEED, 16'h1234);
    send_item(OP_POINT, 16'h1235);
    send_item(OP_POINT, 16'hEDCB);
    send_item(OP_POINT, 16'h8000);
    send_item(OP_POINT, 16'h0001);
    send_item(OP_POINT, 16'h7FFE);
    send_item(OP_RUN, 16'hFFFF);
    write_k(5'd1);
    send_item(OP_RUN, 16'h0000);
    write_k(5'd16);
    send_item(OP_RUN, 16'h5A5A);
  endtask

  task automatic test_store_overflow();
    write_k(5'd3);
    random_job(6, 17);
    write_k(5'd16);
    random_job(4, 18);
  endtask

  task automatic test_backpressure();
    write_k(5'd16);
    random_job(17, 16);
    hold_len = 4000;
    hold_seq++;
    random_job(25, 16);
    random_job(20, 10);
    wait_idle();
  endtask

  task automatic test_random(int n_items);
    int sent;
    int np;
    int ns;
    sent = 0;
    while (sent < n_items) begin
      write_k($urandom_range(9) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16)));
      np = $urandom_range(9) == 0 ? $urandom_range(0, 4) : $urandom_range(2, 24);
      ns = $urandom_range(9) == 0 ? $urandom_range(0, 17) : 16;
      random_job(np, ns);
      sent += np + ns + 1;
    end
  endtask

  // result side: checks each entry against the predictor; random stall plus long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (palette_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected palette entry %h", out_if.centroid_colour);
      end else begin
        palette_entry_t e;
        e = palette_q.pop_front();
        if (out_if.centroid_colour !== e.colour || out_if.centroid_index !== e.idx ||
            out_if.last !== e.last || out_if.converged !== e.conv ||
            out_if.overflow !== e.ovf || out_if.rounds_used !== e.rounds) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp col=%h idx=%0d last=%b conv=%b ovf=%b rnd=%0d",
                     e.colour, e.idx, e.last, e.conv, e.ovf, e.rounds);
            $display("         got col=%h idx=%0d last=%b conv=%b ovf=%b rnd=%0d",
                     out_if.centroid_colour, out_if.centroid_index, out_if.last,
                     out_if.converged, out_if.overflow, out_if.rounds_used);
          end
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= hold_len;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("kmeans_colour_quantizer regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 5'd0;
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_POINT;
    in_if.colour <= 16'h0000;
    seed_cnt = 0;
    dropped = 1'b0;
    k_reg = 5'd16;
    foreach (seed_mem[i]) seed_mem[i] = '0;
    send_idle_pct = 34;
    recv_idle_pct = 56;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_k();
    test_k_extremes();
    test_store_overflow();
    test_backpressure();
    test_random(40);
    send_idle_pct = 56;
    recv_idle_pct = 34;
    test_random(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(40);
    wait_idle();
    if (mismatches == 0 && palette_q.size() == 0) begin
      $display("kmeans_colour_quantizer regression: pass");
    end else begin
      $display("kmeans_colour_quantizer regression: fail");
    end
    $finish;
  end
endmodule
